[design/cardiac_tension_euler_step_defines.svh]
// Assertion macros shared by the cardiac tension block
`ifndef CARDIAC_TENSION_EULER_STEP_DEFINES_SVH
`define CARDIAC_TENSION_EULER_STEP_DEFINES_SVH

// check cons in the same cycle as ante
`define CTE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define CTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/cte_pkg.sv]
`timescale 1ns / 1ps
package cte_pkg;

	typedef logic signed [31:0] word_t;

	localparam int NODES = 4096;
	localparam int NODE_BITS = $clog2(NODES);

	localparam logic [1:0] MODE_WAVE = 2'd0;
	localparam logic [1:0] MODE_TENSION = 2'd1;
	localparam logic [1:0] MODE_HOLD = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic [1:0] REG_MODEL_SELECT = 2'd0;
	localparam logic [1:0] REG_TIME_STEP = 2'd1;

	localparam logic [1:0] MODE_RESET = MODE_TENSION;
	localparam logic [31:0] DT_RESET = 32'd42950;
	localparam logic [31:0] DT5_RESET = 32'd8590;
	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

	localparam word_t WMAX = 32'sh7FFFFFFF;
	localparam word_t WMIN = -32'sh7FFFFFFF - 32'sd1;

	localparam word_t Q_ONE = 32'sd65536;
	localparam word_t Q_DIAST = 32'sd56344;
	localparam word_t Q_OMHC = 32'sd65208;
	localparam word_t Q_TT = 32'sd4587520;
	localparam word_t Q_A = 32'sd3869006;
	localparam word_t Q_Y2E = 32'sd47797;
	localparam word_t Q_Z2 = 32'sd85197;
	localparam word_t Q_NEG_TENTH = -32'sd6554;

	localparam logic signed [15:0] K_Y1 = 16'sd39;
	localparam logic signed [15:0] K_Z1 = 16'sd30;
	localparam logic signed [15:0] K_Y3 = 16'sd30;
	localparam logic signed [15:0] K_Z3 = 16'sd1560;
	localparam logic signed [15:0] K_Y4 = 16'sd40;
	localparam logic signed [15:0] K_YD = 16'sd9;
	localparam logic signed [15:0] K_B = 16'sd1200;
	localparam logic signed [15:0] K_DECAY = 16'sd10;

	typedef struct packed {
		logic [NODE_BITS-1:0] node_index;
		word_t potential;
		word_t calcium;
	} item_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] node_echo;
		word_t activation;
		word_t active_force;
	} result_t;

	typedef struct packed {
		word_t gf;
		word_t tca;
		word_t tcas;
		word_t ts;
		word_t x;
		word_t f;
	} state_t;

	localparam int STATE_BITS = $bits(state_t);

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] dt;
		logic [31:0] dt5;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [NODE_BITS-1:0] node;
		state_t st;
	} wb_t;

	function automatic word_t sat(input logic signed [63:0] v);
		word_t r;
		if (v > 64'(WMAX)) r = WMAX;
		else if (v < 64'(WMIN)) r = WMIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic word_t sadd(input word_t a, input word_t b);
		return sat(64'(a) + 64'(b));
	endfunction

	function automatic word_t ssub(input word_t a, input word_t b);
		return sat(64'(a) - 64'(b));
	endfunction

	function automatic word_t kmul(input word_t a, input logic signed [15:0] k);
		return sat(64'(a) * 64'(k));
	endfunction

	function automatic word_t qmul(input word_t a, input word_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat(p >>> 16);
	endfunction

	function automatic word_t dtmul(input word_t v, input logic [31:0] dt);
		logic signed [64:0] p;
		p = 65'(v) * $signed({33'd0, dt});
		return p[63:32];
	endfunction

endpackage

[design/cte_ram.sv]
`timescale 1ns / 1ps
module cte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

[design/cte_pipe.sv]
`timescale 1ns / 1ps
module cte_pipe (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input cte_pkg::item_t item,
	input cte_pkg::state_t rd,
	input cte_pkg::cfg_t cfg,
	input logic rdy_out,
	input logic [cte_pkg::NODE_BITS-1:0] probe,
	output logic rdy_in,
	output logic hazard,
	output cte_pkg::wb_t wb
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;
	logic [cte_pkg::NODE_BITS-1:0] n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
	cte_pkg::word_t pot_s1, cal_s1;
	cte_pkg::state_t st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8;
	cte_pkg::word_t c_s2, t_s2, dx_s2, p_s2;
	cte_pkg::word_t dx_s3, pct_s3, pa_s3, pb_s3, ptc_s3, s_s3, pp_s3;
	cte_pkg::word_t dx_s4, qb_s4, qa_s4, qr_s4, qd_s4, m1_s4, m2_s4, d0_s4;
	cte_pkg::word_t dx_s5, dtca_s5, dtcas_s5, dts_s5, d0_s5;
	cte_pkg::word_t tca_s6, tcas_s6, ts_s6, x_s6, d0_s6;
	cte_pkg::word_t tca_s7, tcas_s7, ts_s7, x_s7, m_s7, omx_s7, d0_s7;
	cte_pkg::word_t tca_s8, tcas_s8, ts_s8, x_s8, f_s8, dg_s8, d0_s8;

	cte_pkg::word_t c1, t1, dx1, p1;
	cte_pkg::word_t qd1_4, qd2_4;
	cte_pkg::word_t d8, gfn8;
	logic [31:0] dtsel8;
	cte_pkg::state_t res8;

	assign rdy8 = !v_s8 || rdy_out;
	assign rdy7 = !v_s7 || rdy8;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign rdy_in = rdy1;

	assign hazard = (v_s1 && n_s1 == probe) || (v_s2 && n_s2 == probe) ||
		(v_s3 && n_s3 == probe) || (v_s4 && n_s4 == probe) ||
		(v_s5 && n_s5 == probe) || (v_s6 && n_s6 == probe) ||
		(v_s7 && n_s7 == probe) || (v_s8 && n_s8 == probe);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= acc;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
			if (rdy8) v_s8 <= v_s7;
		end
	end

	always_comb begin
		c1 = (cal_s1 <= cte_pkg::Q_DIAST) ? '0 : cal_s1 - cte_pkg::Q_DIAST;
		t1 = cte_pkg::ssub(cte_pkg::ssub(cte_pkg::ssub(cte_pkg::Q_TT, rd.tca), rd.tcas),
			rd.ts);
		dx1 = cte_pkg::kmul(cte_pkg::ssub(cte_pkg::Q_OMHC, rd.x), cte_pkg::K_B);
		p1 = (pot_s1 < 0) ? '0 : pot_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && acc) begin
			n_s1 <= item.node_index;
			pot_s1 <= item.potential;
			cal_s1 <= item.calcium;
		end
		if (rdy2) begin
			n_s2 <= n_s1;
			st_s2 <= rd;
			c_s2 <= c1;
			t_s2 <= t1;
			dx_s2 <= dx1;
			p_s2 <= p1;
		end
		if (rdy3) begin
			n_s3 <= n_s2;
			st_s3 <= st_s2;
			dx_s3 <= dx_s2;
			pct_s3 <= cte_pkg::qmul(c_s2, t_s2);
			pa_s3 <= cte_pkg::qmul(cte_pkg::Q_Y2E, st_s2.tca);
			pb_s3 <= cte_pkg::qmul(cte_pkg::Q_Z2, st_s2.tcas);
			ptc_s3 <= cte_pkg::qmul(st_s2.ts, c_s2);
			s_s3 <= cte_pkg::qmul(dx_s2, dx_s2);
			pp_s3 <= cte_pkg::qmul(p_s2, cte_pkg::Q_NEG_TENTH);
		end
		if (rdy4) begin
			n_s4 <= n_s3;
			st_s4 <= st_s3;
			dx_s4 <= dx_s3;
			qb_s4 <= cte_pkg::ssub(cte_pkg::kmul(pct_s3, cte_pkg::K_Y1),
				cte_pkg::kmul(st_s3.tca, cte_pkg::K_Z1));
			qa_s4 <= cte_pkg::ssub(pa_s3, pb_s3);
			qr_s4 <= cte_pkg::ssub(cte_pkg::kmul(st_s3.tcas, cte_pkg::K_Y3),
				cte_pkg::kmul(ptc_s3, cte_pkg::K_Z3));
			qd_s4 <= cte_pkg::kmul(st_s3.ts, cte_pkg::K_Y4);
			m1_s4 <= cte_pkg::qmul(s_s3, st_s3.ts);
			m2_s4 <= cte_pkg::qmul(s_s3, st_s3.tcas);
			d0_s4 <= cte_pkg::ssub(pp_s3, st_s3.gf);
		end
		if (rdy5) begin
			n_s5 <= n_s4;
			st_s5 <= st_s4;
			dx_s5 <= dx_s4;
			dtca_s5 <= cte_pkg::ssub(qb_s4, qa_s4);
			dtcas_s5 <= cte_pkg::ssub(cte_pkg::ssub(qa_s4, qr_s4), qd2_4);
			dts_s5 <= cte_pkg::ssub(cte_pkg::ssub(qr_s4, qd_s4), qd1_4);
			d0_s5 <= d0_s4;
		end
		if (rdy6) begin
			n_s6 <= n_s5;
			st_s6 <= st_s5;
			tca_s6 <= cte_pkg::sadd(st_s5.tca, cte_pkg::dtmul(dtca_s5, cfg.dt));
			tcas_s6 <= cte_pkg::sadd(st_s5.tcas, cte_pkg::dtmul(dtcas_s5, cfg.dt));
			ts_s6 <= cte_pkg::sadd(st_s5.ts, cte_pkg::dtmul(dts_s5, cfg.dt));
			x_s6 <= cte_pkg::sadd(st_s5.x, cte_pkg::dtmul(dx_s5, cfg.dt));
			d0_s6 <= d0_s5;
		end
		if (rdy7) begin
			n_s7 <= n_s6;
			st_s7 <= st_s6;
			tca_s7 <= tca_s6;
			tcas_s7 <= tcas_s6;
			ts_s7 <= ts_s6;
			x_s7 <= x_s6;
			m_s7 <= cte_pkg::qmul(cte_pkg::Q_A, cte_pkg::sadd(tcas_s6, ts_s6));
			omx_s7 <= cte_pkg::ssub(cte_pkg::Q_ONE, x_s6);
			d0_s7 <= d0_s6;
		end
		if (rdy8) begin
			n_s8 <= n_s7;
			st_s8 <= st_s7;
			tca_s8 <= tca_s7;
			tcas_s8 <= tcas_s7;
			ts_s8 <= ts_s7;
			x_s8 <= x_s7;
			f_s8 <= cte_pkg::qmul(m_s7, omx_s7);
			dg_s8 <= cte_pkg::kmul(st_s7.gf, cte_pkg::K_DECAY);
			d0_s8 <= d0_s7;
		end
	end

	assign qd1_4 = cte_pkg::kmul(m1_s4, cte_pkg::K_YD);
	assign qd2_4 = cte_pkg::kmul(m2_s4, cte_pkg::K_YD);

	always_comb begin
		if (cfg.mode == cte_pkg::MODE_WAVE) begin
			d8 = d0_s8;
			dtsel8 = cfg.dt5;
		end else begin
			d8 = cte_pkg::ssub(cte_pkg::ssub('0, f_s8), dg_s8);
			dtsel8 = cfg.dt;
		end
		gfn8 = cte_pkg::sadd(st_s8.gf, cte_pkg::dtmul(d8, dtsel8));
		case (cfg.mode)
			cte_pkg::MODE_WAVE: begin
				res8 = st_s8;
				res8.gf = gfn8;
			end
			cte_pkg::MODE_TENSION: begin
				res8.gf = gfn8;
				res8.tca = tca_s8;
				res8.tcas = tcas_s8;
				res8.ts = ts_s8;
				res8.x = x_s8;
				res8.f = f_s8;
			end
			default: res8 = st_s8;
		endcase
	end

	assign wb.valid = v_s8 && rdy_out;
	assign wb.node = n_s8;
	assign wb.st = res8;

endmodule

[design/cardiac_tension_euler_step.sv]
`timescale 1ns / 1ps
// Per-node cardiac tension update: each transaction names a node, and its six
// state words are read from one 4096-entry synchronous RAM, advanced by one Euler
// step through an eight-stage arithmetic pipeline and written back; wave mode
// advances only gf, hold and spare keep the state. Transactions for distinct nodes
// are taken one per cycle while the output is not stalled; a transaction whose node
// is still in the pipeline waits until its write-back. After reset a clearing pass
// zeroes all 4096 entries one entry a cycle, during which no transaction is taken;
// configuration writes are taken at any time and belong between transactions.
`include "cardiac_tension_euler_step_defines.svh"
module cardiac_tension_euler_step (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input cte_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output cte_pkg::result_t result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic [cte_pkg::NODE_BITS:0] clr_q;
	logic clr_done;
	logic [1:0] mode_q;
	logic [31:0] dt_q, dt5_q;
	logic [63:0] dt_prod;
	cte_pkg::cfg_t cfg;
	logic acc, rdy_in, hazard, rdy_out, ram_we;
	logic [cte_pkg::NODE_BITS-1:0] ram_waddr;
	logic [cte_pkg::STATE_BITS-1:0] ram_wdata, ram_rdata;
	cte_pkg::wb_t wb;
	logic result_valid_q;
	cte_pkg::result_t result_q;

	assign clr_done = clr_q[cte_pkg::NODE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cte_pkg::MODE_RESET;
			dt_q <= cte_pkg::DT_RESET;
			dt5_q <= cte_pkg::DT5_RESET;
		end else begin
			if (cfg_we && cfg_index == cte_pkg::REG_MODEL_SELECT) mode_q <= cfg_data[1:0];
			if (cfg_we && cfg_index == cte_pkg::REG_TIME_STEP) dt_q <= cfg_data;
			dt5_q <= 32'(dt_prod[63:34]);
		end
	end

	assign dt_prod = 64'(dt_q) * 64'(cte_pkg::RECIP5);
	assign cfg.mode = mode_q;
	assign cfg.dt = dt_q;
	assign cfg.dt5 = dt5_q;

	assign rdy_out = !result_valid_q || result_ready;
	assign acc = item_valid && rdy_in && !hazard && clr_done;
	assign item_ready = rdy_in && !hazard && clr_done;

	assign ram_we = wb.valid || !clr_done;
	assign ram_waddr = clr_done ? wb.node : clr_q[cte_pkg::NODE_BITS-1:0];
	assign ram_wdata = clr_done ? wb.st : '0;

	cte_ram #(
		.WIDTH(cte_pkg::STATE_BITS),
		.DEPTH(cte_pkg::NODES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(acc),
		.raddr(item.node_index),
		.rdata(ram_rdata)
	);

	cte_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.item(item),
		.rd(ram_rdata),
		.cfg(cfg),
		.rdy_out(rdy_out),
		.probe(item.node_index),
		.rdy_in(rdy_in),
		.hazard(hazard),
		.wb(wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rdy_out) begin
			result_valid_q <= wb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wb.valid) begin
			result_q.node_echo <= wb.node;
			result_q.activation <= wb.st.gf;
			result_q.active_force <= wb.st.f;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`CTE_ASSERT_NOW(a_no_take_in_clear, item_valid && item_ready, clr_done,
		"transaction taken during clearing pass")
	`CTE_ASSERT_NOW(a_wb_after_clear, wb.valid, clr_done,
		"write-back during clearing pass")
	`CTE_ASSERT_NEXT(a_wb_gives_result, wb.valid, result_valid,
		"write-back without result")
	`CTE_ASSERT_NEXT(a_clear_stays_done, clr_done, clr_done,
		"clearing pass restarted")

endmodule
